@@ design/fci_pkg.sv @@
// Shared types, constants and helpers of the fan curve interpolator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fci_pkg;

    // Field and register widths
    localparam int TEMP_W    = 16;   // signed Q8.8 temperature
    localparam int PCTIN_W   = 8;    // table percent field
    localparam int PCT_W     = 7;    // output percent
    localparam int SEG_W     = 4;    // output segment index
    localparam int PNT_W     = 24;   // one packed table point
    localparam int CFG_IDX_W = 3;    // register index on the config port
    localparam int REG_COUNT = 8;    // registers in the config map

    // Default table size
    localparam int DEF_TABLE_POINTS = 8;

    // Quotient of the interpolation always fits the percent field
    localparam int DIV_STEPS = PCTIN_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Codes and limits
    localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
    localparam logic [SEG_W-1:0] ABOVE_ALL = 4'd8;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MULT,
        ST_DLOAD,
        ST_DIV,
        ST_FIX,
        ST_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic scan;
        logic mult;
        logic dload;
        logic div_step;
        logic fix;
        logic load_out;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic hit;    // reading at or below the current point
    } t_dp_sts;

    // Clamp a signed percent to 0..100
    function automatic logic [PCT_W-1:0] sat_pct(input logic signed [9:0] v);
        logic [PCT_W-1:0] res;
        if (v < 10'sd0) begin
            res = '0;
        end else if (v > 10'sd100) begin
            res = PCT_MAX;
        end else begin
            res = v[PCT_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/fci_in_if.sv @@
// Input channel of the fan curve interpolator: one temperature reading per item.
// Depends on fci_pkg for the field width.
`default_nettype none

interface fci_in_if;
    import fci_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] reading;

    modport source (output valid, output reading, input ready);
    modport sink   (input valid, input reading, output ready);
endinterface

`default_nettype wire

@@ design/fci_out_if.sv @@
// Output channel of the fan curve interpolator: fan percent and segment per item.
// Depends on fci_pkg for the field widths.
`default_nettype none

interface fci_out_if;
    import fci_pkg::*;

    logic             valid;
    logic             ready;
    logic [PCT_W-1:0] fan_percent;
    logic [SEG_W-1:0] segment;

    modport source (output valid, output fan_percent, output segment, input ready);
    modport sink   (input valid, input fan_percent, input segment, output ready);
endinterface

`default_nettype wire

@@ design/fci_datapath.sv @@
// Datapath: point table, scan compare, multiplier, radix-2 divider, output register.
// Depends on fci_pkg; driven by fci_ctrl through t_dp_cmd.
`default_nettype none

module fci_datapath #(
    parameter int TABLE_POINTS = fci_pkg::DEF_TABLE_POINTS,
    parameter int IDX_W        = $clog2(TABLE_POINTS)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [fci_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [fci_pkg::PNT_W-1:0]         i_cfg_data,
    input  wire logic signed [fci_pkg::TEMP_W-1:0] i_reading,
    input  wire fci_pkg::t_dp_cmd                  i_cmd,
    input  wire logic [IDX_W-1:0]                  i_idx,
    output fci_pkg::t_dp_sts                       o_sts,
    output logic [fci_pkg::PCT_W-1:0]              o_fan_percent,
    output logic [fci_pkg::SEG_W-1:0]              o_segment
);
    import fci_pkg::*;

    logic [PNT_W-1:0]          r_point [TABLE_POINTS];
    logic signed [TEMP_W-1:0]  r_reading;
    logic signed [TEMP_W-1:0]  r_prev_t;
    logic [PCTIN_W-1:0]        r_prev_p;
    logic [TEMP_W+PCTIN_W-1:0] r_prod;
    logic [TEMP_W-1:0]         r_span;
    logic                      r_neg;
    logic [TEMP_W-1:0]         r_rem;
    logic [PCTIN_W-1:0]        r_quo;
    logic [PCT_W-1:0]          r_res_pct;
    logic [SEG_W-1:0]          r_res_seg;
    logic [PCT_W-1:0]          r_out_pct;
    logic [SEG_W-1:0]          r_out_seg;

    logic [PNT_W-1:0]          cur_pnt;
    logic signed [TEMP_W-1:0]  cur_t;
    logic [PCTIN_W-1:0]        cur_p;
    logic signed [TEMP_W:0]    d_read;
    logic signed [TEMP_W:0]    d_span;
    logic signed [PCTIN_W:0]   d_pct;
    logic [PCTIN_W:0]          d_pct_neg;
    logic [PCTIN_W-1:0]        pct_mag;
    logic [TEMP_W+PCTIN_W-1:0] prod_w;
    logic [TEMP_W:0]           trial;
    logic                      trial_ge;
    logic [TEMP_W:0]           trial_sub;
    logic [9:0]                quo_ext;
    logic [9:0]                q_signed;
    logic [9:0]                interp;

    // Configuration registers, one per table point
    for (genvar g = 0; g < TABLE_POINTS; g++) begin : g_point
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_point[g] <= '0;
            end else if (i_cfg_we && i_cfg_index == CFG_IDX_W'(g)) begin
                r_point[g] <= i_cfg_data;
            end
        end
    end

    // Current point fields
    assign cur_pnt = r_point[i_idx];
    assign cur_t   = cur_pnt[TEMP_W-1:0];
    assign cur_p   = cur_pnt[PNT_W-1:TEMP_W];

    assign o_sts.hit = (r_reading <= cur_t);

    // Interpolation operands: distance into segment, span, percent delta
    assign d_read    = {r_reading[TEMP_W-1], r_reading} - {r_prev_t[TEMP_W-1], r_prev_t};
    assign d_span    = {cur_t[TEMP_W-1], cur_t} - {r_prev_t[TEMP_W-1], r_prev_t};
    assign d_pct     = {1'b0, cur_p} - {1'b0, r_prev_p};
    assign d_pct_neg = ~d_pct + (PCTIN_W+1)'(1);
    assign pct_mag   = d_pct[PCTIN_W] ? d_pct_neg[PCTIN_W-1:0] : d_pct[PCTIN_W-1:0];
    assign prod_w    = {{PCTIN_W{1'b0}}, d_read[TEMP_W-1:0]} * {{TEMP_W{1'b0}}, pct_mag};

    // Divider step: remainder stays below the span, one quotient bit a cycle
    assign trial     = {r_rem, r_quo[PCTIN_W-1]};
    assign trial_ge  = (trial >= {1'b0, r_span});
    assign trial_sub = trial - {1'b0, r_span};

    // Floor correction and add to the lower point
    assign quo_ext  = {2'b00, r_quo};
    assign q_signed = r_neg ? (10'd0 - quo_ext - {9'd0, (r_rem != '0)}) : quo_ext;
    assign interp   = {2'b00, r_prev_p} + q_signed;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_reading <= i_reading;
        end
        // Scan: first point or above-all result; otherwise advance the lower point
        if (i_cmd.scan) begin
            r_res_pct <= sat_pct(signed'({2'b00, cur_p}));
            r_res_seg <= o_sts.hit ? SEG_W'(i_idx) : ABOVE_ALL;
            if (!o_sts.hit) begin
                r_prev_t <= cur_t;
                r_prev_p <= cur_p;
            end
        end
        if (i_cmd.mult) begin
            r_prod <= prod_w;
            r_span <= d_span[TEMP_W-1:0];
            r_neg  <= d_pct[PCTIN_W];
        end
        if (i_cmd.dload) begin
            r_rem <= r_prod[TEMP_W+PCTIN_W-1:PCTIN_W];
            r_quo <= r_prod[PCTIN_W-1:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= trial_ge ? trial_sub[TEMP_W-1:0] : trial[TEMP_W-1:0];
            r_quo <= {r_quo[PCTIN_W-2:0], trial_ge};
        end
        if (i_cmd.fix) begin
            r_res_pct <= sat_pct(signed'(interp));
        end
        if (i_cmd.load_out) begin
            r_out_pct <= r_res_pct;
            r_out_seg <= r_res_seg;
        end
    end

    assign o_fan_percent = r_out_pct;
    assign o_segment     = r_out_seg;

endmodule

`default_nettype wire

@@ design/fci_ctrl.sv @@
// Controller: sequences scan, multiply, divide and output handoff for one item.
// Depends on fci_pkg for states and command/status structs.
`default_nettype none

module fci_ctrl #(
    parameter int TABLE_POINTS = fci_pkg::DEF_TABLE_POINTS,
    parameter int IDX_W        = $clog2(TABLE_POINTS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output fci_pkg::t_dp_cmd      o_cmd,
    output logic [IDX_W-1:0]      o_idx,
    input  wire fci_pkg::t_dp_sts i_sts
);
    import fci_pkg::*;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic               last_idx;
    logic               last_step;

    assign last_idx  = (r_idx == IDX_W'(TABLE_POINTS - 1));
    assign last_step = (r_cnt == CNT_W'(DIV_STEPS - 1));

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_idx         = '0;
                    n_state       = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    n_state = (r_idx == '0) ? ST_DONE : ST_MULT;
                end else if (last_idx) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = ST_DLOAD;
            end
            ST_DLOAD: begin
                o_cmd.dload = 1'b1;
                n_cnt       = '0;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (last_step) begin
                    n_state = ST_FIX;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                // Hand off once the output register is free or being emptied
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_idx       = r_idx;

    // Accepted item always starts the scan
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_SCAN))
        else $error("accepted item did not start the scan");

    // Divider runs its full step count
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && !last_step) |=> (r_state == ST_DIV))
        else $error("divider left early");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !i_out_ready)
        |=> (r_state == ST_DONE && r_out_valid))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ design/fan_curve_interpolator.sv @@
// Top level of the fan curve interpolator: config port, channels, controller and datapath.
// Depends on fci_pkg, fci_in_if, fci_out_if, fci_ctrl and fci_datapath.
`default_nettype none

// Maps a signed Q8.8 temperature to a fan percent 0..100 through a table of
// TABLE_POINTS (temperature, percent) points written over the config port.
// Points are examined one per cycle in order; the first whose temperature is
// at or above the reading is used. An item that stops at the first point or
// runs past the last one goes from the scan straight to the output handoff;
// an interpolated item passes in addition through the 16x8 multiply, the
// divider load, eight radix-2 divider steps and the floor correction. One
// item is in work at a time; the block is ready for a new reading in the
// cycle after the previous one has moved into the output register, even
// while that result waits to be taken. The shared bit-serial divider and the
// point scan set the latency.
module fan_curve_interpolator #(
    parameter int TABLE_POINTS = fci_pkg::DEF_TABLE_POINTS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [fci_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [fci_pkg::PNT_W-1:0]     i_cfg_data,
    fci_in_if.sink                             i_in,
    fci_out_if.source                          o_out
);
    import fci_pkg::*;

    localparam int IDX_W = $clog2(TABLE_POINTS);

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic [IDX_W-1:0] idx;

    fci_ctrl #(
        .TABLE_POINTS (TABLE_POINTS),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .o_idx       (idx),
        .i_sts       (sts)
    );

    fci_datapath #(
        .TABLE_POINTS (TABLE_POINTS),
        .IDX_W        (IDX_W)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_reading     (i_in.reading),
        .i_cmd         (cmd),
        .i_idx         (idx),
        .o_sts         (sts),
        .o_fan_percent (o_out.fan_percent),
        .o_segment     (o_out.segment)
    );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for fan_curve_interpolator: a directed probe table, then random
// readings against randomized fan curves, checked by an in-bench curve predictor.
// Depends on fci_pkg, fci_in_if, fci_out_if and the fan_curve_interpolator RTL.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fci_pkg::*;

    localparam int TABLE_POINTS  = DEF_TABLE_POINTS;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int TAIL_CYCLES   = 30;
    localparam int REPORT_MAX    = 10;
    localparam int LONG_HOLD     = 200;
    localparam int HOLD_AT_FIRST = 300;
    localparam int HOLD_AT_LATER = 1000;
    localparam int CURVE_PHASES  = 10;
    localparam int PHASE_ITEMS   = 153;
    localparam int RESET_PROBES  = 4;
    localparam int PROBE_ROWS    = 23;

    localparam logic [7:0] STALL_PATTERN = 8'b1011_0010;

    // How a random fan curve is built
    typedef enum logic [2:0] {
        CURVE_RAMP,     // typical rising curve, moderate steps
        CURVE_SORTED,   // full-range temps, sorted
        CURVE_RAW,      // every register bit random, unsorted
        CURVE_CORNER,   // field extremes mixed in, unsorted
        CURVE_WIDE      // widest possible first span
    } t_curve_kind;

    // Receiver behavior between long hold-offs
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SLOW,
        SINK_PATTERN
    } t_sink_mode;

    typedef struct packed {
        logic [PCT_W-1:0] fan_percent;
        logic [SEG_W-1:0] segment;
    } t_fan_result;

    typedef struct packed {
        logic signed [TEMP_W-1:0] reading;
        logic                     typed;    // use the fan value below, not the predictor
        t_fan_result              fan;
    } t_probe_row;

    // Clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [PNT_W-1:0]     i_cfg_data;

    always #10 i_clk = ~i_clk;

    fci_in_if  in_ch ();
    fci_out_if out_ch ();

    fan_curve_interpolator #(
        .TABLE_POINTS(TABLE_POINTS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Bench copy of the point registers and the curve about to be loaded
    logic [PNT_W-1:0] curve_pts  [REG_COUNT];
    logic [PNT_W-1:0] staged_pts [REG_COUNT];

    t_fan_result pending_fans [$];
    int          bad_count    = 0;
    int          results_seen = 0;
    int          cycle_count  = 0;

    // Hand-built curve: saturated first point, falling and rising spans,
    // a span above 100, an out-of-order point and a 255 percent at the top
    localparam logic [PNT_W-1:0] PROBE_CURVE [REG_COUNT] = '{
        {8'd110, 16'h1400},
        {8'd0,   16'h1E00},
        {8'd60,  16'h2800},
        {8'd200, 16'h3200},
        {8'd100, 16'h3C00},
        {8'd80,  16'h4600},
        {8'd90,  16'h4000},
        {8'd255, 16'h7FFF}
    };

    localparam logic [7:0] CORNER_PCT [4] = '{8'd0, 8'd100, 8'd101, 8'd255};

    // First rows run on the all-zero table after reset, the rest on PROBE_CURVE
    t_probe_row probes [PROBE_ROWS] = '{
        '{16'h8000, 1'b1, '{7'd0, 4'd0}},
        '{16'h0000, 1'b1, '{7'd0, 4'd0}},
        '{16'h0001, 1'b1, '{7'd0, ABOVE_ALL}},
        '{16'h7FFF, 1'b1, '{7'd0, ABOVE_ALL}},
        '{16'h8000, 1'b1, '{PCT_MAX, 4'd0}},
        '{16'h1400, 1'b1, '{PCT_MAX, 4'd0}},
        '{16'h1401, 1'b0, '0},
        '{16'h1900, 1'b0, '0},
        '{16'h1E00, 1'b1, '{7'd0, 4'd1}},
        '{16'h1E01, 1'b0, '0},
        '{16'h2333, 1'b0, '0},
        '{16'h2800, 1'b1, '{7'd60, 4'd2}},
        '{16'h2D00, 1'b0, '0},
        '{16'h2880, 1'b0, '0},
        '{16'h3200, 1'b1, '{PCT_MAX, 4'd3}},
        '{16'h3700, 1'b0, '0},
        '{16'h3C00, 1'b1, '{PCT_MAX, 4'd4}},
        '{16'h4100, 1'b0, '0},
        '{16'h4600, 1'b1, '{7'd80, 4'd5}},
        '{16'h4601, 1'b0, '0},
        '{16'h7FFF, 1'b1, '{PCT_MAX, 4'd7}},
        '{16'h3FFF, 1'b0, '0},
        '{16'hFFFF, 1'b1, '{PCT_MAX, 4'd0}}
    };

    // Clamp an interpolated percent into the output range
    function automatic logic [PCT_W-1:0] clip_percent(input int p);
        if (p < 0) begin
            return '0;
        end
        return (p > 100) ? PCT_MAX : PCT_W'(p);
    endfunction

    // Expected fan output for one reading under the current curve
    function automatic t_fan_result predict_fan(input logic signed [TEMP_W-1:0] r);
        t_fan_result res;
        int rd, prev_t, prev_p, cur_t, cur_p, num, span, q;
        rd     = r;
        prev_t = 0;
        prev_p = 0;
        cur_p  = 0;
        for (int i = 0; i < TABLE_POINTS; i++) begin
            cur_t = $signed(curve_pts[i][TEMP_W-1:0]);
            cur_p = curve_pts[i][PNT_W-1:TEMP_W];
            if (rd <= cur_t) begin
                res.segment = SEG_W'(i);
                if (i == 0) begin
                    res.fan_percent = clip_percent(cur_p);
                end else begin
                    // reading is strictly above prev_t here, so span > 0
                    span = cur_t - prev_t;
                    num  = (rd - prev_t) * (cur_p - prev_p);
                    q    = num / span;
                    if (num < 0 && (num % span) != 0) begin
                        q = q - 1;   // floor, not truncate
                    end
                    res.fan_percent = clip_percent(prev_p + q);
                end
                return res;
            end
            prev_t = cur_t;
            prev_p = cur_p;
        end
        res.segment     = ABOVE_ALL;
        res.fan_percent = clip_percent(cur_p);
        return res;
    endfunction

    // Random reading, mostly near or between the curve's points
    function automatic logic signed [TEMP_W-1:0] pick_reading();
        int sel, t, lo, hi;
        sel = $urandom_range(0, 9);
        t   = $signed(curve_pts[$urandom_range(0, TABLE_POINTS - 1)][TEMP_W-1:0]);
        lo  = 32767;
        hi  = -32768;
        for (int i = 0; i < TABLE_POINTS; i++) begin
            if ($signed(curve_pts[i][TEMP_W-1:0]) < lo) lo = $signed(curve_pts[i][TEMP_W-1:0]);
            if ($signed(curve_pts[i][TEMP_W-1:0]) > hi) hi = $signed(curve_pts[i][TEMP_W-1:0]);
        end
        if (sel < 3) begin
            // exactly on a point
        end else if (sel < 5) begin
            t = t + int'($urandom_range(0, 2)) - 1;
        end else if (sel < 8) begin
            t = lo - 64 + int'($urandom_range(0, hi - lo + 128));
        end else begin
            t = $signed(TEMP_W'($urandom));
        end
        if (t > 32767)  t = 32767;
        if (t < -32768) t = -32768;
        return TEMP_W'(t);
    endfunction

    // Build a random curve into staged_pts
    task automatic stage_curve(input t_curve_kind kind);
        int t, p, tmp;
        int temps [REG_COUNT];
        t = -2560 + int'($urandom_range(0, 10240));
        p = $urandom_range(0, 40);
        for (int i = 0; i < REG_COUNT; i++) begin
            temps[i] = $signed(TEMP_W'($urandom));
        end
        // insertion sort for the sorted full-range curve
        for (int i = 1; i < REG_COUNT; i++) begin
            for (int j = i; j > 0 && temps[j-1] > temps[j]; j--) begin
                tmp        = temps[j];
                temps[j]   = temps[j-1];
                temps[j-1] = tmp;
            end
        end
        for (int i = 0; i < REG_COUNT; i++) begin
            case (kind)
                CURVE_RAMP: begin
                    staged_pts[i] = {8'(p), 16'(t)};
                    t = t + int'($urandom_range(1, 3000));
                    if (t > 32767) t = 32767;
                    p = p + int'($urandom_range(0, 30));
                    if (p > 255) p = 255;
                end
                CURVE_SORTED: staged_pts[i] = {8'($urandom), 16'(temps[i])};
                CURVE_RAW:    staged_pts[i] = PNT_W'($urandom);
                CURVE_CORNER: begin
                    case ($urandom_range(0, 3))
                        0:       tmp = 16'h8000;
                        1:       tmp = 16'h7FFF;
                        2:       tmp = 0;
                        default: tmp = $urandom;
                    endcase
                    staged_pts[i] = {CORNER_PCT[$urandom_range(0, 3)], 16'(tmp)};
                end
                default: staged_pts[i] = PNT_W'($urandom);
            endcase
        end
        if (kind == CURVE_WIDE) begin
            // full 16-bit span with a full 0..255 swing, rising or falling
            p = ($urandom_range(0, 1) == 1) ? 255 : 0;
            staged_pts[0] = {8'(p), 16'h8000};
            staged_pts[1] = {8'(255 - p), 16'h7FFF};
        end
    endtask

    // Write all point registers back to back; block must be idle
    task automatic load_curve();
        for (int i = 0; i < REG_COUNT; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data  <= staged_pts[i];
            @(posedge i_clk);
            curve_pts[i] = staged_pts[i];
        end
        i_cfg_we <= 1'b0;
    endtask

    // Offer one reading; valid is left high for a following item
    task automatic offer_reading(input logic signed [TEMP_W-1:0] r, input logic typed,
                                 input t_fan_result given);
        in_ch.valid   <= 1'b1;
        in_ch.reading <= r;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        pending_fans.push_back(typed ? given : predict_fan(r));
    endtask

    // Wait until every expected result has come back
    task automatic wait_results_done();
        while (pending_fans.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Random readings in bursts; gapless phases keep valid high throughout
    task automatic run_readings(input int count, input logic gapless);
        int burst, gap;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                gap   = gapless ? 0 : $urandom_range(0, 8);
                if (gap > 0) begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            offer_reading(pick_reading(), 1'b0, '0);
            burst--;
        end
        in_ch.valid <= 1'b0;
    endtask

    // Timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: check each item, then choose ready for the next edge
    initial begin : fan_sink
        t_fan_result want;
        t_sink_mode  mode;
        int          mode_left, hold_left, pat_idx;
        out_ch.ready = 1'b0;
        mode         = SINK_OPEN;
        mode_left    = 0;
        hold_left    = 0;
        pat_idx      = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                if (pending_fans.size() == 0) begin
                    if (bad_count < REPORT_MAX) begin
                        $display("unexpected item: fan_percent %0d segment %0d",
                                 out_ch.fan_percent, out_ch.segment);
                    end
                    bad_count++;
                end else begin
                    want = pending_fans.pop_front();
                    if (out_ch.fan_percent !== want.fan_percent ||
                        out_ch.segment !== want.segment) begin
                        if (bad_count < REPORT_MAX) begin
                            $display("mismatch at item %0d: fan_percent %0d/%0d segment %0d/%0d",
                                     results_seen, out_ch.fan_percent, want.fan_percent,
                                     out_ch.segment, want.segment);
                        end
                        bad_count++;
                    end
                end
                results_seen++;
                // long hold-offs so the block fills up and backs up its input
                if (results_seen == HOLD_AT_FIRST || results_seen == HOLD_AT_LATER) begin
                    hold_left = LONG_HOLD;
                end
            end
            if (mode_left == 0) begin
                mode      = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 90);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    SINK_OPEN: out_ch.ready <= 1'b1;
                    SINK_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
                    SINK_SLOW: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: begin
                        out_ch.ready <= STALL_PATTERN[pat_idx];
                        pat_idx = (pat_idx + 1) % 8;
                    end
                endcase
            end
        end
    end

    // Stimulus
    initial begin : readings_source
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        in_ch.valid   = 1'b0;
        in_ch.reading = '0;
        for (int i = 0; i < REG_COUNT; i++) begin
            curve_pts[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: all-zero table straight out of reset
        for (int n = 0; n < RESET_PROBES; n++) begin
            offer_reading(probes[n].reading, probes[n].typed, probes[n].fan);
        end
        in_ch.valid <= 1'b0;
        wait_results_done();

        // Directed: hand-built curve
        staged_pts = PROBE_CURVE;
        load_curve();
        for (int n = RESET_PROBES; n < PROBE_ROWS; n++) begin
            offer_reading(probes[n].reading, probes[n].typed, probes[n].fan);
        end
        in_ch.valid <= 1'b0;
        wait_results_done();

        // Random curves, one phase each
        for (int ph = 0; ph < CURVE_PHASES; ph++) begin
            stage_curve(t_curve_kind'(ph % 5));
            load_curve();
            run_readings(PHASE_ITEMS, (ph % 4) == 3);
            wait_results_done();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (bad_count == 0 && pending_fans.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
